/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/lmpm_pkg.sv */
`timescale 1ns / 1ps

package lmpm_pkg;

  localparam int RULE_COUNT = 15;
  localparam int RULE_IDX_W = 4;
  localparam int HIST_DEPTH = 9;
  localparam int MAX_TOKEN  = 10;
  localparam int LINE_OUT_W = 24;
  localparam int SEV_W      = 2;
  localparam int SCORE_W    = 7;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0a;
  localparam logic [7:0] BYTE_SLASH   = 8'h2f;

  typedef logic [8*MAX_TOKEN-1:0] tok_t;
  typedef logic [RULE_IDX_W-1:0]  rule_idx_t;

  // tokens right-justified: bits [7:0] hold the last character
  localparam tok_t RULE_TOK [RULE_COUNT] = '{
    tok_t'("gets("),    tok_t'("strcpy("),  tok_t'("strcat("),
    tok_t'("sprintf("), tok_t'("vsprintf("), tok_t'("scanf("),
    tok_t'("sscanf("),  tok_t'("strlen("),  tok_t'("system("),
    tok_t'("popen("),   tok_t'("rand("),    tok_t'("srand(time"),
    tok_t'("mktemp("),  tok_t'("tmpnam("),  tok_t'("alloca(")
  };

  localparam logic [3:0] RULE_LEN [RULE_COUNT] = '{
    4'd5, 4'd7, 4'd7, 4'd8, 4'd9, 4'd6, 4'd7, 4'd7,
    4'd7, 4'd6, 4'd5, 4'd10, 4'd7, 4'd7, 4'd7
  };

  localparam logic [SEV_W-1:0] RULE_SEV [RULE_COUNT] = '{
    2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0,
    2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
  };

  localparam logic [SCORE_W-1:0] RULE_SCORE [RULE_COUNT] = '{
    7'd98, 7'd75, 7'd75, 7'd75, 7'd75, 7'd65, 7'd35, 7'd25,
    7'd90, 7'd80, 7'd50, 7'd50, 7'd55, 7'd55, 7'd50
  };

  typedef struct packed {
    logic                  emit;
    rule_idx_t             rule;
    logic [LINE_OUT_W-1:0] line;
  } scan_res_t;

endpackage

/* src/lmpm_scan.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmpm_scan #(
  parameter int LINE_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output lmpm_pkg::scan_res_t res_o
);

  localparam int ExtW = (LINE_BITS > lmpm_pkg::LINE_OUT_W) ? LINE_BITS : lmpm_pkg::LINE_OUT_W;

  logic [7:0]                    hist_q [lmpm_pkg::HIST_DEPTH];
  logic [lmpm_pkg::RULE_COUNT-1:0] hit_q, hit_d, match, hits_all;
  logic [LINE_BITS-1:0]          cnt_q, cnt_d, cnt_inc;
  logic [ExtW-1:0]               cnt_ext;
  logic                          cmt_q, slash_q;
  logic                          is_nl, code_byte, start_cmt, take, line_end;
  lmpm_pkg::rule_idx_t           first_rule;

  assign is_nl     = (byte_i == lmpm_pkg::BYTE_NEWLINE);
  assign code_byte = !is_nl && !cmt_q;
  assign start_cmt = code_byte && slash_q && (byte_i == lmpm_pkg::BYTE_SLASH);
  assign take      = code_byte && !start_cmt;
  assign line_end  = is_nl || last_i;

  // parallel comparators, one per rule, against the byte history
  always_comb begin
    logic ok;
    match = '0;
    for (int k = 0; k < lmpm_pkg::RULE_COUNT; k++) begin
      ok = (byte_i == lmpm_pkg::RULE_TOK[k][7:0]);
      for (int j = 1; j < lmpm_pkg::MAX_TOKEN; j++) begin
        if ((4'(j) < lmpm_pkg::RULE_LEN[k]) &&
            (hist_q[j-1] != lmpm_pkg::RULE_TOK[k][8*j +: 8])) begin
          ok = 1'b0;
        end
      end
      match[k] = ok;
    end
  end

  assign hits_all = take ? (hit_q | match) : hit_q;
  assign hit_d    = hits_all;

  always_comb begin
    first_rule = '0;
    for (int k = lmpm_pkg::RULE_COUNT - 1; k >= 0; k--) begin
      if (hits_all[k]) first_rule = lmpm_pkg::RULE_IDX_W'(k);
    end
  end

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign cnt_d   = line_end ? cnt_inc : cnt_q;
  assign cnt_ext = ExtW'(cnt_inc);

  assign res_o.emit = line_end && (|hits_all);
  assign res_o.rule = first_rule;
  assign res_o.line = cnt_ext[lmpm_pkg::LINE_OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lmpm_pkg::HIST_DEPTH; i++) hist_q[i] <= '0;
      hit_q   <= '0;
      cnt_q   <= '0;
      cmt_q   <= 1'b0;
      slash_q <= 1'b0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
      if (line_end) begin
        for (int i = 0; i < lmpm_pkg::HIST_DEPTH; i++) hist_q[i] <= '0;
        hit_q   <= '0;
        cmt_q   <= 1'b0;
        slash_q <= 1'b0;
      end else begin
        if (start_cmt) cmt_q <= 1'b1;
        if (take) begin
          hist_q[0] <= byte_i;
          for (int i = 1; i < lmpm_pkg::HIST_DEPTH; i++) hist_q[i] <= hist_q[i-1];
          slash_q <= (byte_i == lmpm_pkg::BYTE_SLASH);
          hit_q   <= hit_d;
        end
      end
    end
  end

  `ASSERT_CLK(a_line_end_clears, en_i && line_end |=> hit_q == '0 && !cmt_q && !slash_q,
    "line state not cleared at line end")
  `ASSERT_CLK(a_comment_freezes_hits, cmt_q && en_i && !line_end |=> $stable(hit_q),
    "hits changed inside a comment")
  `ASSERT_CLK(a_counter_saturates, cnt_q == '1 |=> cnt_q == '1,
    "line counter wrapped")

endmodule

/* src/line_multi_pattern_matcher.sv */
`timescale 1ns / 1ps
// a result leaves on m_axis after its closing byte is accepted and passes the input register,
//   then the comparator bank and line state, then the result register
// throughput: one text byte per cycle while m_axis does not stall the result register, set by
//   the comparator bank that updates the per-line history and hit bits
// reset: asynchronous active low; clears valids, line state and the line counter
`include "assert_macros.svh"

module line_multi_pattern_matcher #(
  parameter int LINE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] text_byte
  input  logic        s_axis_tlast_i,  // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // [23:0] line_number, [27:24] rule_index,
                                       // [29:28] severity, [36:30] score_tenths
);

  logic                      s1_valid_q, s1_last_q;
  logic [7:0]                s1_byte_q;
  logic                      out_free, s1_adv;
  logic                      out_valid_q;
  logic [lmpm_pkg::LINE_OUT_W-1:0] out_line_q;
  lmpm_pkg::rule_idx_t       out_rule_q;
  logic [lmpm_pkg::SEV_W-1:0]   out_sev_q;
  logic [lmpm_pkg::SCORE_W-1:0] out_score_q;
  lmpm_pkg::scan_res_t       res;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_byte_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
  end

  lmpm_scan #(
    .LINE_BITS(LINE_BITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (s1_adv),
    .byte_i(s1_byte_q),
    .last_i(s1_last_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res.emit) begin
      out_line_q  <= res.line;
      out_rule_q  <= res.rule;
      out_sev_q   <= lmpm_pkg::RULE_SEV[res.rule];
      out_score_q <= lmpm_pkg::RULE_SCORE[res.rule];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_score_q, out_sev_q, out_rule_q, out_line_q};

  `ASSERT_CLK(a_s1_holds_on_stall, s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q),
    "pending byte lost while result stalled")
  `ASSERT_CLK(a_rule_in_range,
    out_valid_q |-> out_rule_q < lmpm_pkg::RULE_IDX_W'(lmpm_pkg::RULE_COUNT),
    "rule index out of range")
  `ASSERT_CLK(a_score_matches_rule,
    out_valid_q |-> out_score_q == lmpm_pkg::RULE_SCORE[out_rule_q],
    "score does not match rule")

endmodule

/* test/line_multi_pattern_matcher_tb.sv */
`timescale 1ns / 1ps

module line_multi_pattern_matcher_tb;

  localparam int LINE_W     = 24;
  localparam int RULES      = 15;
  localparam int HIST       = 9;
  localparam int TEXT_ITEMS = 2000;

  localparam logic [1:0] SEV_LOW      = 2'd0;
  localparam logic [1:0] SEV_MEDIUM   = 2'd1;
  localparam logic [1:0] SEV_HIGH     = 2'd2;
  localparam logic [1:0] SEV_CRITICAL = 2'd3;

  // matches the tdata layout, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic [6:0]        score;
    logic [1:0]        sev;
    logic [3:0]        rule;
    logic [LINE_W-1:0] line;
  } finding_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } text_item_t;

  string rule_token [RULES] = '{
    "gets(", "strcpy(", "strcat(", "sprintf(", "vsprintf(", "scanf(",
    "sscanf(", "strlen(", "system(", "popen(", "rand(", "srand(time",
    "mktemp(", "tmpnam(", "alloca("
  };
  logic [1:0] rule_sev [RULES] = '{
    SEV_CRITICAL, SEV_HIGH, SEV_HIGH, SEV_HIGH, SEV_HIGH, SEV_MEDIUM,
    SEV_LOW, SEV_LOW, SEV_CRITICAL, SEV_HIGH, SEV_MEDIUM, SEV_MEDIUM,
    SEV_MEDIUM, SEV_MEDIUM, SEV_MEDIUM
  };
  logic [6:0] rule_score [RULES] = '{
    7'd98, 7'd75, 7'd75, 7'd75, 7'd75, 7'd65, 7'd35, 7'd25,
    7'd90, 7'd80, 7'd50, 7'd50, 7'd55, 7'd55, 7'd50
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;

  text_item_t text_q [$];
  finding_t   finding_q [$];
  int         mismatches = 0;
  int         cyc = 0;

  // line scanner state
  logic [7:0]        recent [HIST];
  logic [RULES-1:0]  hits = '0;
  logic [LINE_W-1:0] line_cnt = '0;
  bit                in_comment = 1'b0;
  bit                slash_seen = 1'b0;

  line_multi_pattern_matcher DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic void clear_line();
    for (int i = 0; i < HIST; i++) recent[i] = 8'd0;
    hits = '0;
    in_comment = 1'b0;
    slash_seen = 1'b0;
  endfunction

  function automatic void scan_text(logic [7:0] ch, logic last);
    int n;
    bit m;
    finding_t f;
    if (ch != lmpm_pkg::BYTE_NEWLINE && !in_comment) begin
      if (slash_seen && ch == lmpm_pkg::BYTE_SLASH) begin
        in_comment = 1'b1;
      end else begin
        for (int k = 0; k < RULES; k++) begin
          n = rule_token[k].len();
          m = (rule_token[k][n-1] == ch);
          for (int i = 0; i + 1 < n; i++)
            if (recent[i] != rule_token[k][n-2-i]) m = 1'b0;
          if (m) hits[k] = 1'b1;
        end
        for (int i = HIST - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = ch;
        slash_seen = (ch == lmpm_pkg::BYTE_SLASH);
      end
    end
    if (ch == lmpm_pkg::BYTE_NEWLINE || last) begin
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
      for (int k = 0; k < RULES; k++) begin
        if (hits[k]) begin
          f = '0;
          f.line  = line_cnt;
          f.rule  = k[3:0];
          f.sev   = rule_sev[k];
          f.score = rule_score[k];
          finding_q.insert(finding_q.size(), f);
          break;
        end
      end
      clear_line();
    end
  endfunction

  function automatic void push_char(logic [7:0] ch, logic last, bit drain);
    text_item_t t;
    t.ch = ch;
    t.last = last;
    t.drain = drain;
    text_q.insert(text_q.size(), t);
  endfunction

  // last flag goes on the final character of s when set
  function automatic void push_text(string s, logic last);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], last && (i == s.len() - 1), 1'b0);
  endfunction

  function automatic int gen_line(bit drain);
    logic [7:0] ln [$];
    string      s;
    string      noise;
    int         nfrag;
    int         idx;
    int         kind;
    noise = "abcdefgilmnoprstuvy (;*";
    nfrag = $urandom_range(0, 6);
    for (int f = 0; f < nfrag; f++) begin
      s = "";
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = rule_token[$urandom_range(0, RULES - 1)];
        4: begin
          // almost a token: one character changed or the tail cut off
          s = rule_token[$urandom_range(0, RULES - 1)];
          if ($urandom_range(0, 1)) begin
            idx = $urandom_range(0, s.len() - 1);
            s[idx] = noise[$urandom_range(0, noise.len() - 1)];
          end else begin
            s = s.substr(0, s.len() - 2);
          end
        end
        5: s = $urandom_range(0, 1) ? "//" : "/";
        6: ln.insert(ln.size(), 8'($urandom_range(0, 255)));
        7, 8: begin
          idx = $urandom_range(1, 4);
          for (int i = 0; i < idx; i++)
            ln.insert(ln.size(), noise[$urandom_range(0, noise.len() - 1)]);
        end
        default: s = " ";
      endcase
      for (int i = 0; i < s.len(); i++) ln.insert(ln.size(), s[i]);
    end
    kind = $urandom_range(0, 19);
    if (kind < 2 && ln.size() > 0) begin
      for (int i = 0; i < ln.size(); i++)
        push_char(ln[i], i == ln.size() - 1, drain && i == 0);
      return ln.size();
    end
    for (int i = 0; i < ln.size(); i++) push_char(ln[i], 1'b0, drain && i == 0);
    push_char(lmpm_pkg::BYTE_NEWLINE, kind < 3, drain && ln.size() == 0);
    return ln.size() + 1;
  endfunction

  function automatic bit quiet_stretch();
    return cyc >= 1000 && cyc < 1800;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    text_item_t t;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'd0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_axis_tready_o) scan_text(s_tdata, s_tlast);
      if (!s_tvalid || s_axis_tready_o) begin
        if (text_q.size() > 0 && (quiet_stretch() || $urandom_range(0, 99) >= 25) &&
            !(text_q[0].drain && finding_q.size() > 0)) begin
          t = text_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= t.ch;
          s_tlast  <= t.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    finding_t got;
    finding_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        got = m_axis_tdata_o;
        if (finding_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected finding line=%0d rule=%0d sev=%0d score=%0d pad=%0h",
                     $realtime, got.line, got.rule, got.sev, got.score, got.pad);
          mismatches++;
        end else begin
          want = finding_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: finding mismatch exp line=%0d rule=%0d sev=%0d score=%0d pad=%0h, %s",
                       $realtime, want.line, want.rule, want.sev, want.score, want.pad,
                       $sformatf("got line=%0d rule=%0d sev=%0d score=%0d pad=%0h",
                                 got.line, got.rule, got.sev, got.score, got.pad));
            mismatches++;
          end
        end
      end
      m_tready <= quiet_stretch() || $urandom_range(0, 99) >= 25;
    end
  end

  initial begin
    int sent;
    clear_line();
    // directed lines
    push_text("gets(\n", 1'b0);
    push_text("xsscanf(", 1'b1);     // inner token wins, line closed by last
    push_char(lmpm_pkg::BYTE_NEWLINE, 1'b1, 1'b0); // newline marked last, empty line
    push_text("a//gets(\n", 1'b0);   // token inside a comment
    push_char(8'hff, 1'b0, 1'b0);
    push_char(8'h00, 1'b1, 1'b0);    // line without a hit
    sent = 0;
    while (sent < TEXT_ITEMS)
      sent += gen_line(sent == 0 || (sent >= TEXT_ITEMS / 2 && sent < TEXT_ITEMS / 2 + 12));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() > 0 || s_tvalid) @(posedge clk_i);
    while (finding_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
